[rtl/core/rpw_pkg.sv]
// Shared types, field widths and codes for the recursive page table walker.
// No dependencies; imported by rpw_step and recursive_page_walk_translate.

package rpw_pkg;

    // Field widths
    localparam int ADDR_W   = 64;
    localparam int PHYS_W   = 52;
    localparam int SLOT_W   = 9;
    localparam int SIZE_W   = 2;
    localparam int LEVEL_W  = 2;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 120;

    // Reset value of the recursive slot register
    localparam logic [SLOT_W-1:0] SLOT_RESET = 9'd510;

    // Input action codes
    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_ENTRY   = 1'b1;

    // Result kinds
    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // Walk status on finish
    localparam logic STAT_MAPPED     = 1'b0;
    localparam logic STAT_NOT_MAPPED = 1'b1;

    // Page size codes
    localparam logic [SIZE_W-1:0] SIZE_4K = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_2M = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_1G = 2'd2;

    // Table levels
    localparam logic [LEVEL_W-1:0] LVL_PML4 = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_PDPT = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_PD   = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_PT   = 2'd3;

    // Entry bit positions
    localparam int BIT_PRESENT = 0;
    localparam int BIT_HUGE    = 7;

    // Walker state
    typedef struct packed {
        logic               busy;
        logic [LEVEL_W-1:0] level;
        logic [ADDR_W-1:0]  saved_va;
    } rpw_state_t;

    // One result item
    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] read_address;
        logic              status;
        logic [PHYS_W-1:0] phys;
        logic [SIZE_W-1:0] size;
    } rpw_result_t;

endpackage

[rtl/core/rpw_step.sv]
// Combinational step of the page walker: next state and result for one item.
// Depends on rpw_pkg for the state and result types and the codes.

module rpw_step
    import rpw_pkg::*;
(
    input  logic               action,
    input  logic [ADDR_W-1:0]  virtual_address,
    input  logic [ADDR_W-1:0]  entry_value,
    input  logic [SLOT_W-1:0]  recursive_slot,
    input  rpw_state_t         state_cur,
    output rpw_state_t         state_nxt,
    output logic               fire,
    output rpw_result_t        result
);

    // Recursive address of the entry read at a level, made canonical
    function automatic logic [ADDR_W-1:0] entry_addr(
        input logic [LEVEL_W-1:0] level,
        input logic [ADDR_W-1:0]  va,
        input logic [SLOT_W-1:0]  r
    );
        logic [SLOT_W-1:0] i4;
        logic [SLOT_W-1:0] i3;
        logic [SLOT_W-1:0] i2;
        logic [SLOT_W-1:0] i1;
        logic [47:0]       low;
        i4 = va[47:39];
        i3 = va[38:30];
        i2 = va[29:21];
        i1 = va[20:12];
        case (level)
            LVL_PML4: low = {r,  r,  r,  r,  i4, 3'b000};
            LVL_PDPT: low = {r,  r,  r,  i4, i3, 3'b000};
            LVL_PD:   low = {r,  r,  i4, i3, i2, 3'b000};
            default:  low = {r,  i4, i3, i2, i1, 3'b000};
        endcase
        return {{16{low[47]}}, low};
    endfunction

    logic present;
    logic huge;
    logic [ADDR_W-1:0] va;

    assign present = entry_value[BIT_PRESENT];
    assign huge    = entry_value[BIT_HUGE];
    assign va      = state_cur.saved_va;

    always_comb
    begin
        state_nxt = state_cur;
        fire      = 1'b0;
        result    = '0;
        if (action == ACT_REQUEST)
        begin
            // new request, ignored while a walk is in progress
            if (!state_cur.busy)
            begin
                state_nxt.busy     = 1'b1;
                state_nxt.level    = LVL_PML4;
                state_nxt.saved_va = virtual_address;
                fire               = 1'b1;
                result.kind        = KIND_READ;
                result.read_address = entry_addr(LVL_PML4, virtual_address, recursive_slot);
            end
        end
        else if (state_cur.busy)
        begin
            fire = 1'b1;
            if (!present)
            begin
                state_nxt.busy  = 1'b0;
                state_nxt.level = LVL_PML4;
                result.kind     = KIND_FINISH;
                result.status   = STAT_NOT_MAPPED;
            end
            else if (state_cur.level == LVL_PDPT && huge)
            begin
                state_nxt.busy  = 1'b0;
                state_nxt.level = LVL_PML4;
                result.kind     = KIND_FINISH;
                result.status   = STAT_MAPPED;
                result.phys     = {entry_value[51:30], va[29:0]};
                result.size     = SIZE_1G;
            end
            else if (state_cur.level == LVL_PD && huge)
            begin
                state_nxt.busy  = 1'b0;
                state_nxt.level = LVL_PML4;
                result.kind     = KIND_FINISH;
                result.status   = STAT_MAPPED;
                result.phys     = {entry_value[51:21], va[20:0]};
                result.size     = SIZE_2M;
            end
            else if (state_cur.level == LVL_PT)
            begin
                state_nxt.busy  = 1'b0;
                state_nxt.level = LVL_PML4;
                result.kind     = KIND_FINISH;
                result.status   = STAT_MAPPED;
                result.phys     = {entry_value[51:12], va[11:0]};
                result.size     = SIZE_4K;
            end
            else
            begin
                // descend one level and ask for the next entry
                state_nxt.level     = state_cur.level + 2'd1;
                result.kind         = KIND_READ;
                result.read_address = entry_addr(state_cur.level + 2'd1, va,
                                                 recursive_slot);
            end
        end
    end

endmodule

[rtl/core/recursive_page_walk_translate.sv]
// Top level of the recursive four-level page table walker.
// Depends on rpw_pkg and rpw_step; rpw_check binds to it.

// One item is taken per clock cycle, sustained, whenever the result side
// keeps up. An accepted item is held in the input register, is
// evaluated against the walk state by rpw_step and lands in the result
// register. The walk state (busy, level, saved address) updates together
// with the result register, which sustains that rate. Requests that
// arrive during a walk and entries that arrive with no walk open are
// consumed without a result.
// The recursive slot (reset 510) may be written at any idle time; cfg_ready
// is always high.

module recursive_page_walk_translate
    import rpw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write: recursive_slot
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [SLOT_W-1:0]     cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [63:0] virtual_address, [127:64] entry_value
    input  logic                  s_axis_tuser,   // [0] action
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [63:0] read_address, [64] walk_status,
                                                  // [116:65] physical_address,
                                                  // [118:117] page_size_code, [119] zero
    output logic                  m_axis_tuser    // [0] result_kind
);

    logic [SLOT_W-1:0] slot_reg;
    logic              in_valid_reg;
    logic              in_action_reg;
    logic [ADDR_W-1:0] in_va_reg;
    logic [ADDR_W-1:0] in_entry_reg;
    rpw_state_t        state_reg;
    rpw_state_t        state_next;
    logic              out_valid_reg;
    rpw_result_t       out_reg;
    rpw_result_t       result_next;
    logic              fire;
    logic              advance;
    logic              in_xfer;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // recursive slot register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= SLOT_RESET;
        else if (cfg_valid && cfg_ready)
            slot_reg <= cfg_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_xfer)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_action_reg <= s_axis_tuser;
            in_va_reg     <= s_axis_tdata[63:0];
            in_entry_reg  <= s_axis_tdata[127:64];
        end
    end

    rpw_step u_step (
        .action          (in_action_reg),
        .virtual_address (in_va_reg),
        .entry_value     (in_entry_reg),
        .recursive_slot  (slot_reg),
        .state_cur       (state_reg),
        .state_nxt       (state_next),
        .fire            (fire),
        .result          (result_next)
    );

    // walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= fire;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && fire)
            out_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {1'b0, out_reg.size, out_reg.phys, out_reg.status,
                            out_reg.read_address};

endmodule

[rtl/core/rpw_check.sv]
// Port-level checks for the recursive page table walker, bound to the top.
// Depends on rpw_pkg for codes; attaches to recursive_page_walk_translate.

module rpw_check
    import rpw_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    logic              is_read;
    logic              is_finish;
    logic [ADDR_W-1:0] raddr;
    logic              status;
    logic [PHYS_W-1:0] phys;
    logic [SIZE_W-1:0] size;

    assign is_read   = m_axis_tvalid && (m_axis_tuser == KIND_READ);
    assign is_finish = m_axis_tvalid && (m_axis_tuser == KIND_FINISH);
    assign raddr     = m_axis_tdata[63:0];
    assign status    = m_axis_tdata[64];
    assign phys      = m_axis_tdata[116:65];
    assign size      = m_axis_tdata[118:117];

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // read requests are canonical, 8-byte aligned and carry no translation
    assert property (@(posedge clk) disable iff (!rst_n)
        is_read |-> (raddr[63:48] == {16{raddr[47]}}) && (raddr[2:0] == 3'b000)
            && (status == STAT_MAPPED) && (phys == '0) && (size == SIZE_4K))
        else $error("malformed read request");

    // a not-mapped finish carries nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        is_finish && (status == STAT_NOT_MAPPED) |->
            (raddr == '0) && (phys == '0) && (size == SIZE_4K))
        else $error("not-mapped finish with payload");

    // a mapped finish has a valid size and no read address
    assert property (@(posedge clk) disable iff (!rst_n)
        is_finish && (status == STAT_MAPPED) |->
            (raddr == '0) && (size == SIZE_4K || size == SIZE_2M || size == SIZE_1G))
        else $error("bad mapped finish");

endmodule

bind recursive_page_walk_translate rpw_check u_rpw_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[verif/tb_recursive_page_walk_translate.sv]
// Self-checking testbench for recursive_page_walk_translate: drives requests and table
// entries on the input stream, predicts each read request or translation, checks the results.
// Depends on rpw_pkg and the walker RTL only.
`timescale 1ns / 100ps

import rpw_pkg::*;

// Tracks the walk as the block should see it and holds the results still owed
class walk_tracker;
    logic [SLOT_W-1:0]  slot;
    logic               busy;
    logic [LEVEL_W-1:0] level;
    logic [ADDR_W-1:0]  saved_va;
    rpw_result_t        owed_results[$];
    int                 errors;

    function new();
        slot     = SLOT_RESET;
        busy     = 1'b0;
        level    = LVL_PML4;
        saved_va = '0;
        errors   = 0;
    endfunction

    function void set_slot(logic [SLOT_W-1:0] value);
        slot = value;
    endfunction

    function int outstanding();
        return owed_results.size();
    endfunction

    // Recursive address built from five 9-bit fields, sign-extended from bit 47
    function logic [ADDR_W-1:0] recursive_address(logic [8:0] a, logic [8:0] b,
                                                   logic [8:0] c, logic [8:0] d,
                                                   logic [8:0] e);
        logic [ADDR_W-1:0] x;
        x = (64'(a) << 39) | (64'(b) << 30) | (64'(c) << 21) | (64'(d) << 12) | (64'(e) << 3);
        if (x[47])
            x[63:48] = '1;
        return x;
    endfunction

    // Entry address read at a given table level for the saved address
    function logic [ADDR_W-1:0] table_entry_address(logic [LEVEL_W-1:0] lvl);
        logic [8:0] i4, i3, i2, i1;
        i4 = saved_va[47:39];
        i3 = saved_va[38:30];
        i2 = saved_va[29:21];
        i1 = saved_va[20:12];
        case (lvl)
            LVL_PML4: return recursive_address(slot, slot, slot, slot, i4);
            LVL_PDPT: return recursive_address(slot, slot, slot, i4, i3);
            LVL_PD:   return recursive_address(slot, slot, i4, i3, i2);
            default:  return recursive_address(slot, i4, i3, i2, i1);
        endcase
    endfunction

    // Advance the walk for one accepted transfer; returns 1 if a result is owed
    function bit note_transfer(logic act, logic [ADDR_W-1:0] va, logic [ADDR_W-1:0] ent);
        rpw_result_t r;
        r = '0;
        if (act == ACT_REQUEST) begin
            // a request during a walk is dropped
            if (busy)
                return 1'b0;
            saved_va = va;
            busy     = 1'b1;
            level    = LVL_PML4;
            r.kind   = KIND_READ;
            r.read_address = table_entry_address(LVL_PML4);
            owed_results.push_back(r);
            return 1'b1;
        end
        // an entry with no walk open is dropped
        if (!busy)
            return 1'b0;
        if (!ent[BIT_PRESENT]) begin
            r.kind   = KIND_FINISH;
            r.status = STAT_NOT_MAPPED;
        end else if (level == LVL_PDPT && ent[BIT_HUGE]) begin
            r.kind = KIND_FINISH;
            r.phys = {ent[51:30], saved_va[29:0]};
            r.size = SIZE_1G;
        end else if (level == LVL_PD && ent[BIT_HUGE]) begin
            r.kind = KIND_FINISH;
            r.phys = {ent[51:21], saved_va[20:0]};
            r.size = SIZE_2M;
        end else if (level == LVL_PT) begin
            // huge bit means nothing at the last level
            r.kind = KIND_FINISH;
            r.phys = {ent[51:12], saved_va[11:0]};
            r.size = SIZE_4K;
        end else begin
            // huge bit means nothing at the top level either
            level = level + 1'b1;
            r.kind = KIND_READ;
            r.read_address = table_entry_address(level);
        end
        if (r.kind == KIND_FINISH) begin
            busy  = 1'b0;
            level = LVL_PML4;
        end
        owed_results.push_back(r);
        return 1'b1;
    endfunction

    function void report(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    // Compare one result transfer with the oldest owed result
    function void check_result(logic kind, logic [OUT_DATA_W-1:0] data);
        rpw_result_t want;
        if (owed_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0d data %h",
                     $time, kind, data);
            return;
        end
        want = owed_results.pop_front();
        if (kind !== want.kind)
            report("result_kind", 64'(want.kind), 64'(kind));
        if (data[63:0] !== want.read_address)
            report("read_address", want.read_address, data[63:0]);
        if (data[64] !== want.status)
            report("walk_status", 64'(want.status), 64'(data[64]));
        if (data[116:65] !== want.phys)
            report("physical_address", 64'(want.phys), 64'(data[116:65]));
        if (data[118:117] !== want.size)
            report("page_size_code", 64'(want.size), 64'(data[118:117]));
        if (data[119] !== 1'b0)
            report("tdata padding", 64'(0), 64'(data[119]));
    endfunction
endclass

module tb_recursive_page_walk_translate;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [SLOT_W-1:0]     cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [63:0] virtual_address, [127:64] entry_value
    logic                  s_axis_tuser = 1'b0; // [0] action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [63:0] read_address, [64] walk_status,
                                                // [116:65] physical_address,
                                                // [118:117] page_size_code, [119] zero
    logic                  m_axis_tuser;        // [0] result_kind

    walk_tracker tracker = new();
    bit          steady_flow = 1'b0;             // no idling on either side while set
    int          results_sent;

    recursive_page_walk_translate dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // Run limit
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Result side: check each transfer, stall at random
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                tracker.check_result(m_axis_tuser, m_axis_tdata);
            m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 20);
        end
    end

    // One input transfer, with a random gap in front of it
    task automatic send_item(input logic act, input logic [ADDR_W-1:0] va,
                             input logic [ADDR_W-1:0] ent);
        while (!steady_flow && $urandom_range(0, 99) < 20)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {ent, va};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (tracker.note_transfer(act, va, ent))
            results_sent++;
    endtask

    // Hold the input side until every owed result has come and the pipe is empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_slot(input logic [SLOT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.set_slot(value);
    endtask

    // Mostly well-formed walks with random content, some dropped items mixed in
    task automatic random_walks(input int count);
        logic [ADDR_W-1:0] va, ent;
        int                stop_at;
        stop_at = results_sent + count;
        while (results_sent < stop_at)
        begin
            va  = {$urandom, $urandom};
            ent = {$urandom, $urandom};
            if ($urandom_range(0, 3) != 0)
                va[63:48] = {16{va[47]}};
            ent[BIT_PRESENT] = ($urandom_range(0, 99) < 88);
            ent[BIT_HUGE]    = ($urandom_range(0, 99) < 30);
            if (tracker.busy)
                send_item(($urandom_range(0, 99) < 8) ? ACT_REQUEST : ACT_ENTRY, va, ent);
            else
                send_item(($urandom_range(0, 99) < 10) ? ACT_ENTRY : ACT_REQUEST, va, ent);
        end
    endtask

    initial
    begin
        logic [SLOT_W-1:0] slot_plan[6];
        results_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero address, page absent at the top level
        send_item(ACT_REQUEST, 64'h0, 64'h0);
        send_item(ACT_ENTRY, 64'h0, 64'h0);
        // all-ones address; huge bit at the top level is ignored, then a 1GB page
        send_item(ACT_REQUEST, '1, '1);
        send_item(ACT_ENTRY, '1, 64'h0000_0000_0000_0081);
        send_item(ACT_ENTRY, '1, '1);
        // sign extension from bit 47, then a 2MB page
        send_item(ACT_REQUEST, 64'h0000_7FFF_FFFF_FFFF, '0);
        send_item(ACT_ENTRY, '0, 64'h1);
        send_item(ACT_ENTRY, '0, 64'h1);
        send_item(ACT_ENTRY, '0, '1);
        // non-canonical address; huge bit at the last level still gives 4KB
        send_item(ACT_REQUEST, 64'h8000_0000_0000_0000, '0);
        send_item(ACT_ENTRY, '0, 64'h1);
        send_item(ACT_ENTRY, '0, 64'h1);
        send_item(ACT_ENTRY, '0, 64'h1);
        send_item(ACT_ENTRY, '0, '1);
        // entry with no walk open, dropped
        send_item(ACT_ENTRY, '1, '1);
        // request during a walk is dropped; absent at the last level
        send_item(ACT_REQUEST, 64'h0000_1234_5678_9ABC, '0);
        send_item(ACT_REQUEST, '1, '1);
        send_item(ACT_ENTRY, '0, 64'h0000_0000_0000_0001);
        send_item(ACT_ENTRY, '0, 64'h0000_0000_0000_0001);
        send_item(ACT_ENTRY, '0, 64'h0000_0000_0000_0001);
        send_item(ACT_ENTRY, '0, 64'hFFFF_FFFF_FFFF_FFFE);
        // absent at the PD level, huge bit clear in the entry
        send_item(ACT_REQUEST, 64'hFFFF_8000_0000_0000, '0);
        send_item(ACT_ENTRY, '0, 64'h1);
        send_item(ACT_ENTRY, '0, 64'h1);
        send_item(ACT_ENTRY, '0, 64'hFFFF_FFFF_FFFF_FF7E);
        drain();

        // Random phases, each under its own recursive slot
        slot_plan = '{9'd0, 9'd511, 9'(
            $urandom), 9'd1, 9'($urandom), 9'd510};
        for (int phase = 0; phase < 6; phase++)
        begin
            write_slot(slot_plan[phase]);
            steady_flow = (phase == 2);
            random_walks(195);
            drain();
        end
        steady_flow = 1'b0;

        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
